// ===== sv/e2q_pkg.sv =====
// Package for the Euler-angle to quaternion pipeline.
// Holds field widths, Q30 constants, the CORDIC arctangent table and request types.
// No dependencies.
`timescale 1ns / 1ps

package e2q_pkg;

  localparam int ANGLE_WIDTH  = 16;
  localparam int QUAT_WIDTH   = 16;
  localparam int CORDIC_ITERS = 30;
  localparam int Q30_W        = 32;

  typedef logic signed [Q30_W-1:0] q30_t;

  localparam q30_t              Q30_HALF_PI = 32'sd1686629713;
  localparam logic signed [32:0] Q30_PI     = 33'sd3373259426;
  localparam q30_t              Q30_GAIN    = 32'sd652032875;

  // Plus one in the output format
  localparam logic signed [QUAT_WIDTH-1:0] QUAT_ONE =
    QUAT_WIDTH'(1) <<< (QUAT_WIDTH - 2);

  // atan(2^-i) in Q30
  localparam q30_t ATAN_Q30 [CORDIC_ITERS] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159, 32'sd67021687,
    32'sd33543516,  32'sd16775851,  32'sd8388437,   32'sd4194283,   32'sd2097149,
    32'sd1048576,   32'sd524288,    32'sd262144,    32'sd131072,    32'sd65536,
    32'sd32768,     32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
    32'sd1024,      32'sd512,       32'sd256,       32'sd128,       32'sd64,
    32'sd32,        32'sd16,        32'sd8,         32'sd4,         32'sd2
  };

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] heading_angle;
    logic signed [ANGLE_WIDTH-1:0] attitude_angle;
    logic signed [ANGLE_WIDTH-1:0] bank_angle;
  } in_req_t;

  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] quat_w;
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;
  } out_req_t;

  // Q30 product, rounded half up
  function automatic q30_t mul_q30(q30_t a, q30_t b);
    logic signed [2*Q30_W-1:0] p;
    p = 64'(a) * 64'(b);
    p = p + (64'sd1 <<< (Q30_W - 3));
    return q30_t'(p >>> (Q30_W - 2));
  endfunction

endpackage

// ===== sv/e2q_sincos.sv =====
// One pipelined CORDIC lane: cosine and sine of half an Euler angle in Q30.
// Fold stage, one stage per iteration, then a sign-flip output stage.
// Depends on e2q_pkg.
`timescale 1ns / 1ps

module e2q_sincos import e2q_pkg::*; (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [ANGLE_WIDTH-1:0] angle_i,
  output q30_t                          cos_o,
  output q30_t                          sin_o
);

  q30_t x_q    [CORDIC_ITERS+1];
  q30_t y_q    [CORDIC_ITERS+1];
  q30_t z_q    [CORDIC_ITERS+1];
  logic flip_q [CORDIC_ITERS+1];

  q30_t              z_in;
  logic signed [32:0] z_ext;
  q30_t              z0_d;
  logic              flip0_d;
  q30_t              cos_q, sin_q;

  // Half angle in Q30, then fold into [-pi/2, pi/2]
  always_comb begin
    z_in  = q30_t'(angle_i) <<< (Q30_W - ANGLE_WIDTH);
    z_ext = 33'(z_in);
    if (z_in > Q30_HALF_PI) begin
      z0_d    = q30_t'(z_ext - Q30_PI);
      flip0_d = 1'b1;
    end else if (z_in < -Q30_HALF_PI) begin
      z0_d    = q30_t'(z_ext + Q30_PI);
      flip0_d = 1'b1;
    end else begin
      z0_d    = z_in;
      flip0_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= Q30_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= z0_d;
      flip_q[0] <= flip0_d;
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    q30_t x_d, y_d, z_d;

    always_comb begin
      if (!z_q[i][Q30_W-1]) begin
        x_d = x_q[i] - (y_q[i] >>> i);
        y_d = y_q[i] + (x_q[i] >>> i);
        z_d = z_q[i] - ATAN_Q30[i];
      end else begin
        x_d = x_q[i] + (y_q[i] >>> i);
        y_d = y_q[i] - (x_q[i] >>> i);
        z_d = z_q[i] + ATAN_Q30[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= x_d;
        y_q[i+1]    <= y_d;
        z_q[i+1]    <= z_d;
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= flip_q[CORDIC_ITERS] ? -x_q[CORDIC_ITERS] : x_q[CORDIC_ITERS];
      sin_q <= flip_q[CORDIC_ITERS] ? -y_q[CORDIC_ITERS] : y_q[CORDIC_ITERS];
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// ===== sv/e2q_quat_mul.sv =====
// Product network: pair products, triple products, then sum, round and saturate.
// Three register stages, the last one is the output register.
// Depends on e2q_pkg.
`timescale 1ns / 1ps

module e2q_quat_mul import e2q_pkg::*; (
  input  logic     clk_i,
  input  logic     en_i,
  input  q30_t     c1_i,
  input  q30_t     s1_i,
  input  q30_t     c2_i,
  input  q30_t     s2_i,
  input  q30_t     c3_i,
  input  q30_t     s3_i,
  output out_req_t quat_o
);

  localparam int SH = Q30_W - QUAT_WIDTH;
  localparam logic signed [33:0] RND = (34'sd1 <<< SH) >>> 1;
  localparam logic signed [33:0] LIM = 34'sd1 <<< (QUAT_WIDTH - 2);

  q30_t cc_q, ss_q, sc_q, cs_q, c3_q, s3_q;
  q30_t w1_q, w2_q, x1_q, x2_q, y1_q, y2_q, z1_q, z2_q;
  out_req_t quat_q;

  function automatic logic signed [QUAT_WIDTH-1:0] quat_out(q30_t a, q30_t b, logic sub);
    logic signed [33:0] v;
    v = sub ? (34'(a) - 34'(b)) : (34'(a) + 34'(b));
    v = (v + RND) >>> SH;
    if (v > LIM) begin
      v = LIM;
    end else if (v < -LIM) begin
      v = -LIM;
    end
    return QUAT_WIDTH'(v);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q <= mul_q30(c1_i, c2_i);
      ss_q <= mul_q30(s1_i, s2_i);
      sc_q <= mul_q30(s1_i, c2_i);
      cs_q <= mul_q30(c1_i, s2_i);
      c3_q <= c3_i;
      s3_q <= s3_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w1_q <= mul_q30(cc_q, c3_q);
      w2_q <= mul_q30(ss_q, s3_q);
      x1_q <= mul_q30(cc_q, s3_q);
      x2_q <= mul_q30(ss_q, c3_q);
      y1_q <= mul_q30(sc_q, c3_q);
      y2_q <= mul_q30(cs_q, s3_q);
      z1_q <= mul_q30(cs_q, c3_q);
      z2_q <= mul_q30(sc_q, s3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quat_q.quat_w <= quat_out(w1_q, w2_q, 1'b1);
      quat_q.quat_x <= quat_out(x1_q, x2_q, 1'b0);
      quat_q.quat_y <= quat_out(y1_q, y2_q, 1'b0);
      quat_q.quat_z <= quat_out(z1_q, z2_q, 1'b1);
    end
  end

  assign quat_o = quat_q;

endmodule

// ===== sv/euler_to_quaternion_top.sv =====
// Euler angles (heading, attitude, bank) to unit quaternion, fully pipelined.
// Stages: fold, 30 CORDIC iterations and sign fix per lane, then 3 product stages.
// Throughput one request per cycle; the whole pipeline holds while the output is not taken.
// Reset clears only the stage valid bits; data registers are not reset.
// Depends on e2q_pkg, e2q_sincos, e2q_quat_mul.
`timescale 1ns / 1ps

module euler_to_quaternion_top import e2q_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_data_o
);

  localparam int NSTG = CORDIC_ITERS + 2 + 3;

  logic [NSTG-1:0] valid_q;
  logic            en;
  q30_t            c1, s1, c2, s2, c3, s3;

  // Advance when the last stage is empty or being taken; otherwise everything holds as one
  assign en = !valid_q[NSTG-1] || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NSTG-2:0], in_valid_i};
    end
  end

  e2q_sincos u_heading (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_data_i.heading_angle),
    .cos_o   (c1),
    .sin_o   (s1)
  );

  e2q_sincos u_attitude (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_data_i.attitude_angle),
    .cos_o   (c2),
    .sin_o   (s2)
  );

  e2q_sincos u_bank (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_data_i.bank_angle),
    .cos_o   (c3),
    .sin_o   (s3)
  );

  e2q_quat_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (en),
    .c1_i   (c1),
    .s1_i   (s1),
    .c2_i   (c2),
    .s2_i   (s2),
    .c3_i   (c3),
    .s3_i   (s3),
    .quat_o (out_data_o)
  );

  assign in_ready_o  = en;
  assign out_valid_o = valid_q[NSTG-1];

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted request did not enter the pipeline");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_q))
    else $error("valid bits moved during a stall");

  a_w_saturated : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_data_o.quat_w) <= QUAT_ONE) &&
                    ($signed(out_data_o.quat_w) >= -QUAT_ONE))
    else $error("quat_w outside plus or minus one");

  a_z_saturated : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_data_o.quat_z) <= QUAT_ONE) &&
                    ($signed(out_data_o.quat_z) >= -QUAT_ONE))
    else $error("quat_z outside plus or minus one");

endmodule
